// ===== src/chunk_framer_crc16_header_core_assert.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef CHUNK_FRAMER_CRC16_HEADER_CORE_ASSERT_SVH
`define CHUNK_FRAMER_CRC16_HEADER_CORE_ASSERT_SVH

// same-cycle implication
`define CFCRC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cfcrc assertion failed");

// next-cycle implication
`define CFCRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cfcrc assertion failed");

`endif

// ===== src/cfcrc_pkg.sv =====
// shared types, constants and the crc step for the chunk framer
// no dependencies
package cfcrc_pkg;

  localparam int MAX_CHUNK_WORDS = 60;
  localparam int STORE_DEPTH     = 2 * MAX_CHUNK_WORDS;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam int APB_AW          = 5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    KIND_INDEX,
    KIND_LENGTH,
    KIND_CRC,
    KIND_OFFSET,
    KIND_DATA
  } kind_e;

  typedef enum logic [2:0] {
    REG_CHUNK_WORDS,
    REG_INDEX_BASE,
    REG_LITTLE_ENDIAN,
    REG_DATA_ADDRESS,
    REG_INDEX_ADDRESS,
    REG_LENGTH_ADDRESS,
    REG_CRC_ADDRESS,
    REG_OFFSET_ADDRESS
  } reg_e;

  typedef struct packed {
    logic [5:0]  chunk_words;
    logic [15:0] index_base;
    logic        little_endian;
    logic [15:0] data_address;
    logic [16:0] index_address;
    logic [16:0] length_address;
    logic [16:0] crc_address;
    logic [16:0] offset_address;
  } cfg_t;

  typedef struct packed {
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    kind_e       write_kind;
    logic        chunk_end;
    logic        payload_end;
    logic        range_error;
  } result_t;

  // crc-16/modbus over one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/cfcrc_regs.sv =====
// apb register file holding the framer configuration
// depends on cfcrc_pkg
module cfcrc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfcrc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output cfcrc_pkg::cfg_t              cfg_o
);

  cfcrc_pkg::cfg_t cfg_q;
  cfcrc_pkg::reg_e sel;
  logic            wr_en;

  assign sel   = cfcrc_pkg::reg_e'(paddr[cfcrc_pkg::APB_AW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_words    <= 6'(cfcrc_pkg::MAX_CHUNK_WORDS);
      cfg_q.index_base     <= '0;
      cfg_q.little_endian  <= 1'b0;
      cfg_q.data_address   <= '0;
      cfg_q.index_address  <= '1;
      cfg_q.length_address <= '1;
      cfg_q.crc_address    <= '1;
      cfg_q.offset_address <= '1;
    end else if (wr_en) begin
      unique case (sel)
        cfcrc_pkg::REG_CHUNK_WORDS:    cfg_q.chunk_words    <= pwdata[5:0];
        cfcrc_pkg::REG_INDEX_BASE:     cfg_q.index_base     <= pwdata[15:0];
        cfcrc_pkg::REG_LITTLE_ENDIAN:  cfg_q.little_endian  <= pwdata[0];
        cfcrc_pkg::REG_DATA_ADDRESS:   cfg_q.data_address   <= pwdata[15:0];
        cfcrc_pkg::REG_INDEX_ADDRESS:  cfg_q.index_address  <= pwdata[16:0];
        cfcrc_pkg::REG_LENGTH_ADDRESS: cfg_q.length_address <= pwdata[16:0];
        cfcrc_pkg::REG_CRC_ADDRESS:    cfg_q.crc_address    <= pwdata[16:0];
        cfcrc_pkg::REG_OFFSET_ADDRESS: cfg_q.offset_address <= pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      cfcrc_pkg::REG_CHUNK_WORDS:    prdata = {26'd0, cfg_q.chunk_words};
      cfcrc_pkg::REG_INDEX_BASE:     prdata = {16'd0, cfg_q.index_base};
      cfcrc_pkg::REG_LITTLE_ENDIAN:  prdata = {31'd0, cfg_q.little_endian};
      cfcrc_pkg::REG_DATA_ADDRESS:   prdata = {16'd0, cfg_q.data_address};
      cfcrc_pkg::REG_INDEX_ADDRESS:  prdata = {15'd0, cfg_q.index_address};
      cfcrc_pkg::REG_LENGTH_ADDRESS: prdata = {15'd0, cfg_q.length_address};
      cfcrc_pkg::REG_CRC_ADDRESS:    prdata = {15'd0, cfg_q.crc_address};
      cfcrc_pkg::REG_OFFSET_ADDRESS: prdata = {15'd0, cfg_q.offset_address};
    endcase
  end

endmodule

// ===== src/cfcrc_engine.sv =====
// chunk buffer memory, running crc and the write sequencer
// depends on cfcrc_pkg
module cfcrc_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfcrc_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfcrc_pkg::result_t   out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_RDA,
    ST_RDB,
    ST_WORD
  } state_e;

  localparam int AW = cfcrc_pkg::STORE_AW;

  state_e               state_q;
  logic [AW-1:0]        fill_q;
  logic [15:0]          crc_q;
  logic [15:0]          pcount_q;
  logic [16:0]          offset_q;
  logic                 last_q;
  logic [1:0]           hk_q;
  logic [AW-1:0]        wi_q;
  logic [7:0]           first_q;
  logic [7:0]           rdata_q;
  logic                 o_valid_q;
  logic                 o_valid_d;
  cfcrc_pkg::result_t   out_q;

  logic [7:0]           mem [cfcrc_pkg::STORE_DEPTH];

  logic                 accept;
  logic                 room;
  logic [AW-1:0]        fill_inc;
  logic [15:0]          crc_next;
  logic [5:0]           words;
  logic [AW-1:0]        size;
  logic                 close;
  logic                 out_free;
  logic                 emit;
  logic                 hdr_en;
  cfcrc_pkg::result_t   hdr_res;
  cfcrc_pkg::result_t   word_res;
  logic                 word_last;
  logic [7:0]           second;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [17:0]          offset_sum;
  logic [16:0]          offset_sat;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign room     = fill_q < AW'(cfcrc_pkg::STORE_DEPTH);
  assign fill_inc = room ? fill_q + AW'(1) : fill_q;
  assign crc_next = cfcrc_pkg::crc_byte(crc_q, in_byte_i);
  assign out_free = !o_valid_q || out_ready_i;

  // chunk size in bytes, word count clamped to 1..max
  always_comb begin
    priority if (cfg_i.chunk_words == 6'd0) begin
      words = 6'd1;
    end else if (cfg_i.chunk_words > 6'(cfcrc_pkg::MAX_CHUNK_WORDS)) begin
      words = 6'(cfcrc_pkg::MAX_CHUNK_WORDS);
    end else begin
      words = cfg_i.chunk_words;
    end
  end
  assign size  = {words, 1'b0};
  assign close = (fill_inc >= size) || in_last_i;

  // header selection
  always_comb begin
    hdr_res             = '0;
    hdr_res.write_kind  = cfcrc_pkg::kind_e'({1'b0, hk_q});
    unique case (hk_q)
      2'd0: begin
        hdr_en            = !cfg_i.index_address[16];
        hdr_res.reg_address = cfg_i.index_address[15:0];
        hdr_res.reg_value = cfg_i.index_base + pcount_q;
      end
      2'd1: begin
        hdr_en            = !cfg_i.length_address[16];
        hdr_res.reg_address = cfg_i.length_address[15:0];
        hdr_res.reg_value = {{(16-AW){1'b0}}, fill_q};
      end
      2'd2: begin
        hdr_en            = !cfg_i.crc_address[16];
        hdr_res.reg_address = cfg_i.crc_address[15:0];
        hdr_res.reg_value = crc_q;
      end
      default: begin
        hdr_en            = !cfg_i.offset_address[16];
        hdr_res.reg_address = cfg_i.offset_address[15:0];
        hdr_res.reg_value = offset_q[15:0];
        hdr_res.range_error = offset_q[16];
      end
    endcase
  end

  // data word assembly, second byte zero past the chunk length
  assign second    = ({1'b0, wi_q} + 8'd1 < {1'b0, fill_q}) ? rdata_q : 8'h00;
  assign word_last = ({1'b0, wi_q} + 8'd2) >= {1'b0, fill_q};

  always_comb begin
    word_res             = '0;
    word_res.write_kind  = cfcrc_pkg::KIND_DATA;
    word_res.reg_address = cfg_i.data_address + {{(17-AW){1'b0}}, wi_q[AW-1:1]};
    word_res.reg_value   = cfg_i.little_endian ? {second, first_q} : {first_q, second};
    word_res.chunk_end   = word_last;
    word_res.payload_end = word_last && last_q;
  end

  assign offset_sum = {1'b0, offset_q} + {{(18-AW){1'b0}}, fill_q};
  assign offset_sat = offset_sum[17] ? '1 : offset_sum[16:0];

  // output register loads on an enabled header slot or a data slot, clears once taken
  assign emit      = out_free && (((state_q == ST_HDR) && hdr_en) || (state_q == ST_WORD));
  assign o_valid_d = emit || (o_valid_q && !out_ready_i);

  // even byte first, then odd byte of the same word
  assign rd_en   = (state_q == ST_RDA) || (state_q == ST_RDB);
  assign rd_addr = (state_q == ST_RDB) ? (wi_q | AW'(1)) : wi_q;

  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      mem[fill_q] <= in_byte_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      crc_q     <= cfcrc_pkg::CRC_INIT;
      pcount_q  <= '0;
      offset_q  <= '0;
      last_q    <= 1'b0;
      hk_q      <= '0;
      wi_q      <= '0;
      first_q   <= '0;
      out_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            fill_q <= fill_inc;
            crc_q  <= crc_next;
            if (close) begin
              last_q  <= in_last_i;
              hk_q    <= '0;
              wi_q    <= '0;
              state_q <= ST_HDR;
            end
          end
        end
        ST_HDR: begin
          if (!hdr_en || out_free) begin
            if (hdr_en) begin
              out_q <= hdr_res;
            end
            hk_q <= hk_q + 2'd1;
            if (hk_q == 2'd3) begin
              state_q <= ST_RDA;
            end
          end
        end
        ST_RDA: begin
          state_q <= ST_RDB;
        end
        ST_RDB: begin
          first_q <= rdata_q;
          state_q <= ST_WORD;
        end
        ST_WORD: begin
          if (out_free) begin
            out_q <= word_res;
            if (word_last) begin
              fill_q  <= '0;
              crc_q   <= cfcrc_pkg::CRC_INIT;
              state_q <= ST_IDLE;
              if (last_q) begin
                pcount_q <= '0;
                offset_q <= '0;
              end else begin
                pcount_q <= pcount_q + 16'd1;
                offset_q <= offset_sat;
              end
            end else begin
              wi_q    <= wi_q + AW'(2);
              state_q <= ST_RDA;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = o_valid_q;
  assign out_o       = out_q;

endmodule

// ===== src/chunk_framer_crc16_header_core.sv =====
// top level of the chunk framer with crc-16/modbus header writes
// depends on cfcrc_pkg, cfcrc_regs, cfcrc_engine
//
//   channel   dir   handshake                 carries
//   s_axis    in    tvalid/tready             one payload byte, tlast on the final byte
//   m_axis    out   tvalid/tready             one register write, tlast on payload end
//   apb       in    psel/penable/pready       configuration registers at 4*index
//
// a byte that does not close a chunk leaves the framer idle and ready for the next byte
// closing a chunk runs the four header slots, then reads each data word from the
// single-port chunk memory one byte per cycle and emits it; output stalls add to that
// a result waits in the output register while the next byte can already be taken
// reset is asynchronous, active low; the chunk memory needs no clearing
module chunk_framer_crc16_header_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  input  logic                         s_axis_tlast,   // last_byte
  // stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,   // [15:0] reg_address, [31:16] reg_value
  output logic [4:0]                   m_axis_tuser,   // [2:0] write_kind, [3] chunk_end,
                                                       // [4] range_error
  output logic                         m_axis_tlast,   // payload_end
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfcrc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  cfcrc_pkg::cfg_t    cfg;
  cfcrc_pkg::result_t res;

  // configuration registers
  cfcrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // buffering, crc and write sequencing
  cfcrc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // word packing on the output side
  assign m_axis_tdata = {res.reg_value, res.reg_address};
  assign m_axis_tuser = {res.range_error, res.chunk_end, res.write_kind};
  assign m_axis_tlast = res.payload_end;

endmodule

// ===== src/cfcrc_chk.sv =====
// port-level checker for the chunk framer, bound to the top level
// depends on cfcrc_pkg and the assertion macro header
`include "chunk_framer_crc16_header_core_assert.svh"

module cfcrc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled word holds
  `CFCRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // header writes never close a chunk or the payload
  `CFCRC_ASSERT_IMPL(a_hdr_flags, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[2:0] != cfcrc_pkg::KIND_DATA), !m_axis_tuser[3] && !m_axis_tlast)

  // range error only on the offset header
  `CFCRC_ASSERT_IMPL(a_rerr_kind, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[4], m_axis_tuser[2:0] == cfcrc_pkg::KIND_OFFSET)

  // payload end coincides with the last data word of a chunk
  `CFCRC_ASSERT_IMPL(a_pend_cend, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[3])

endmodule

bind chunk_framer_crc16_header_core cfcrc_chk u_cfcrc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
